// ----- rtl/sha256_message_hash_core_assert.svh -----
// ----------------------------------------------------------------------------
// SHA-256 core assertion macros
// Concurrent checks sampled on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_HASH_CORE_ASSERT_SVH
`define SHA256_MESSAGE_HASH_CORE_ASSERT_SVH

// Same-cycle implication
`define SHA256_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SHA256_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sha256_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 core package
// Channel payload types, control bundles, round constants and initial hash.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
  } digest_t;

  typedef struct packed {
    logic       shift_byte;
    logic       shift_word;
    logic [7:0] byte_in;
  } sched_ctl_t;

  typedef struct packed {
    logic       init;
    logic       step;
    logic       fold;
    logic       load_iv;
    logic [2:0] rd_idx;
  } rnd_ctl_t;

  localparam logic       ACT_ABSORB = 1'b0;
  localparam logic       ACT_FINISH = 1'b1;
  localparam logic [7:0] PAD_LEAD   = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] LAST_POS   = 6'h3F;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD  = 3'd7;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667;
      3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f;
      3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      3'd7: h = 32'h5be0cd19;
      default: h = 32'h0;
    endcase
    return h;
  endfunction

endpackage

// ----- rtl/sha256_message_hash_core.sv -----
// ----------------------------------------------------------------------------
// SHA-256 message hash core
// Absorb: one byte per cycle while idle; the byte that fills a block starts a
//   busy compression (64 rounds in the shared round unit, then a feed-forward step).
// Finish: one padding byte per cycle up to the block end, a compression per
//   block (one or two), then 8 digest words, one per output transfer.
// Reset: hash words to the initial values, byte count to zero, idle.
// ----------------------------------------------------------------------------
module sha256_message_hash_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  sha256_pkg::item_t   item,
  output logic                digest_valid,
  input  logic                digest_stall,
  output sha256_pkg::digest_t digest
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_COMP = 3'd1;
  localparam logic [2:0] ST_FOLD = 3'd2;
  localparam logic [2:0] ST_PAD  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]  state, state_next;
  logic [2:0]  ret, ret_next;
  logic [60:0] cnt, cnt_next;
  logic [5:0]  pos, pos_next;
  logic        pad_first, pad_first_next;
  logic        len_phase, len_phase_next;
  logic [63:0] len_sr, len_sr_next;
  logic [5:0]  rnd, rnd_next;
  logic [2:0]  emit_idx, emit_idx_next;

  logic        item_accept;
  logic        slot_free;
  logic        load_word;
  logic [5:0]  pos_inc;
  logic [7:0]  pad_byte;
  logic [31:0] w0;
  logic [31:0] hash_word;

  sha256_pkg::sched_ctl_t sctl;
  sha256_pkg::rnd_ctl_t   rctl;

  assign item_stall  = (state != ST_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign slot_free   = !digest_valid || !digest_stall;

  sha256_sched u_sched (
    .clk (clk),
    .ctl (sctl),
    .w0  (w0)
  );

  sha256_round u_round (
    .clk       (clk),
    .rst       (rst),
    .ctl       (rctl),
    .k         (sha256_pkg::round_k(rnd)),
    .w         (w0),
    .hash_word (hash_word)
  );

  always_comb begin
    state_next     = state;
    ret_next       = ret;
    cnt_next       = cnt;
    pos_next       = pos;
    pad_first_next = pad_first;
    len_phase_next = len_phase;
    len_sr_next    = len_sr;
    rnd_next       = rnd;
    emit_idx_next  = emit_idx;
    sctl           = '0;
    rctl           = '0;
    rctl.rd_idx    = emit_idx;
    load_word      = 1'b0;
    pos_inc        = pos + 6'd1;
    pad_byte       = 8'h00;

    case (state)
      ST_IDLE: begin
        if (item_accept) begin
          if (item.action == sha256_pkg::ACT_ABSORB) begin
            sctl.shift_byte = 1'b1;
            sctl.byte_in    = item.data_byte;
            cnt_next        = cnt + 61'd1;
            if (cnt[5:0] == sha256_pkg::LAST_POS) begin
              rctl.init  = 1'b1;
              rnd_next   = '0;
              ret_next   = ST_IDLE;
              state_next = ST_COMP;
            end
          end else begin
            // latch bit length and restart the count for the next message
            pos_next       = cnt[5:0];
            len_sr_next    = {cnt, 3'b000};
            cnt_next       = '0;
            pad_first_next = 1'b1;
            len_phase_next = 1'b0;
            state_next     = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        if (pad_first) begin
          pad_byte = sha256_pkg::PAD_LEAD;
        end else if (len_phase) begin
          pad_byte = len_sr[63:56];
        end
        sctl.shift_byte = 1'b1;
        sctl.byte_in    = pad_byte;
        pos_next        = pos_inc;
        pad_first_next  = 1'b0;
        if (len_phase) begin
          len_sr_next = {len_sr[55:0], 8'h00};
        end
        if (pos_inc == '0) begin
          rctl.init      = 1'b1;
          rnd_next       = '0;
          ret_next       = len_phase ? ST_EMIT : ST_PAD;
          len_phase_next = 1'b0;
          state_next     = ST_COMP;
        end else if (pos_inc == sha256_pkg::LEN_POS) begin
          len_phase_next = 1'b1;
        end
      end

      ST_COMP: begin
        rctl.step       = 1'b1;
        sctl.shift_word = 1'b1;
        rnd_next        = rnd + 6'd1;
        if (rnd == sha256_pkg::LAST_ROUND) begin
          state_next = ST_FOLD;
        end
      end

      ST_FOLD: begin
        rctl.fold     = 1'b1;
        emit_idx_next = '0;
        state_next    = ret;
      end

      ST_EMIT: begin
        if (slot_free) begin
          load_word     = 1'b1;
          emit_idx_next = emit_idx + 3'd1;
          if (emit_idx == sha256_pkg::LAST_WORD) begin
            // word 7 is read this cycle; restore the initial hash behind it
            rctl.load_iv = 1'b1;
            state_next   = ST_IDLE;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ret          <= ST_IDLE;
      cnt          <= '0;
      pos          <= '0;
      pad_first    <= 1'b0;
      len_phase    <= 1'b0;
      rnd          <= '0;
      emit_idx     <= '0;
      digest_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      cnt       <= cnt_next;
      pos       <= pos_next;
      pad_first <= pad_first_next;
      len_phase <= len_phase_next;
      rnd       <= rnd_next;
      emit_idx  <= emit_idx_next;
      if (slot_free) begin
        digest_valid <= load_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    len_sr <= len_sr_next;
    if (load_word) begin
      digest.digest_word <= hash_word;
      digest.word_index  <= emit_idx;
      digest.last        <= (emit_idx == sha256_pkg::LAST_WORD);
    end
  end

`include "sha256_message_hash_core_assert.svh"

  `SHA256_ASSERT_IMP(a_last_index, digest_valid && digest.last, digest.word_index == 3'd7, "last flag on a word other than the final one")
  `SHA256_ASSERT_NXT(a_round_end, state == ST_COMP && rnd == 6'd63, state == ST_FOLD, "compression did not fold after round 63")
  `SHA256_ASSERT_IMP(a_len_pos, len_phase && state == ST_PAD, pos[5:3] == 3'b111, "length bytes outside the block tail")
  `SHA256_ASSERT_NXT(a_emit_burst, digest_valid && !digest_stall && !digest.last, digest_valid, "digest words not delivered back to back")

endmodule

// ----- rtl/sha256_sched.sv -----
// ----------------------------------------------------------------------------
// SHA-256 block buffer and message schedule
// One 512-bit shift line: bytes shift in while the block fills, then one
// expanded schedule word shifts in per round. Oldest word sits on top.
// ----------------------------------------------------------------------------
module sha256_sched (
  input  logic                   clk,
  input  sha256_pkg::sched_ctl_t ctl,
  output logic [31:0]            w0
);

  logic [511:0] blk;
  logic [31:0]  w1;
  logic [31:0]  w9;
  logic [31:0]  w14;
  logic [31:0]  w_new;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  always_comb begin
    w0    = blk[511:480];
    w1    = blk[479:448];
    w9    = blk[223:192];
    w14   = blk[63:32];
    w_new = ssig1(w14) + w9 + ssig0(w1) + w0;
  end

  always_ff @(posedge clk) begin
    if (ctl.shift_byte) begin
      blk <= {blk[503:0], ctl.byte_in};
    end else if (ctl.shift_word) begin
      blk <= {blk[479:0], w_new};
    end
  end

endmodule

// ----- rtl/sha256_round.sv -----
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Working variables a..h, one compression round per cycle, and the eight
// hash words with their feed-forward add.
// ----------------------------------------------------------------------------
module sha256_round (
  input  logic                 clk,
  input  logic                 rst,
  input  sha256_pkg::rnd_ctl_t ctl,
  input  logic [31:0]          k,
  input  logic [31:0]          w,
  output logic [31:0]          hash_word
);

  logic [31:0] hash [8];
  logic [31:0] v    [8];
  logic [31:0] t1;
  logic [31:0] t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
         ((v[4] & v[5]) ^ (~v[4] & v[6])) + k + w;
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
         ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    hash_word = hash[ctl.rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.load_iv) begin
      for (int j = 0; j < 8; j++) begin
        hash[j] <= sha256_pkg::init_hash(3'(j));
      end
    end else if (ctl.fold) begin
      for (int j = 0; j < 8; j++) begin
        hash[j] <= hash[j] + v[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      for (int j = 0; j < 8; j++) begin
        v[j] <= hash[j];
      end
    end else if (ctl.step) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

endmodule
